### hdl/euler_to_rotation_matrix_core_macros.svh
// Assertion macros shared by the rotation matrix RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, prop, msg)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/rotm_pkg.sv
// Shared types, widths and constants of the rotation matrix core.
// Depends on nothing.
package rotm_pkg;

   localparam int ANGLE_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 14;

   localparam int PHASE_W      = 32;
   localparam int CORDIC_STEPS = 30;
   localparam int XY_W         = 34;
   localparam int Z_W          = 32;
   localparam int TRIG_W       = 32;
   localparam int PROD_W       = 64;
   localparam int SUM_W        = 66;
   localparam int OUT_W        = 16;

   // input stage + one stage per step + quadrant stage
   localparam int CORDIC_LAT = CORDIC_STEPS + 2;
   localparam int MATRIX_LAT = 5;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN_INV = XY_W'(32'h26DD3B6A);
   localparam logic signed [PROD_W:0] HALF_Q30 = (PROD_W+1)'(64'd1 << 29);

   localparam logic [29:0] STEP_ANGLE [CORDIC_STEPS] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
   };

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_v;
      logic signed [TRIG_W-1:0] cos_v;
   } trig_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] fwd_x;
      logic signed [OUT_W-1:0] fwd_y;
      logic signed [OUT_W-1:0] fwd_z;
      logic signed [OUT_W-1:0] left_x;
      logic signed [OUT_W-1:0] left_y;
      logic signed [OUT_W-1:0] left_z;
      logic signed [OUT_W-1:0] up_x;
      logic signed [OUT_W-1:0] up_y;
      logic signed [OUT_W-1:0] up_z;
   } matrix_type;

   // Q30 x Q30 -> Q60
   function automatic logic signed [PROD_W-1:0] mul_q30(
      input logic signed [TRIG_W-1:0] a,
      input logic signed [TRIG_W-1:0] b
   );
      mul_q30 = a * b;
   endfunction

   // Q60 -> Q30, round half up
   function automatic logic signed [TRIG_W-1:0] rnd_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] t;
      t = (PROD_W+1)'(p) + HALF_Q30;
      rnd_q30 = t[TRIG_W+29:30];
   endfunction

endpackage

### hdl/rotm_cordic.sv
// Pipelined rotation CORDIC: one binary angle in, Q2.30 sine and cosine out.
// Depends on rotm_pkg and the assertion macro header.
`include "euler_to_rotation_matrix_core_macros.svh"
module rotm_cordic
   import rotm_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic                  out_valid,
   output trig_type              trig
);

   localparam int PAD_W = PHASE_W - ANGLE_BITS;
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;
   localparam logic signed [TRIG_W-1:0] TRIG_LIM = TRIG_W'((64'd1 << 30) + 64'd256);
   localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(64);

   logic [PHASE_W-1:0]     phase;
   logic signed [XY_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] x_in [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] y_in [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_ff [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]  z_in [0:CORDIC_STEPS];
   logic [1:0]             quad_ff [0:CORDIC_STEPS];
   logic [1:0]             quad_in [0:CORDIC_STEPS];
   logic [CORDIC_STEPS:0]  valid_ff, valid_in;
   logic signed [XY_W-1:0] xl, yl;
   trig_type               trig_ff, trig_in;
   logic                   trig_valid_ff;

   assign phase = {angle, {PAD_W{1'b0}}};

   always_comb begin
      x_in[0]    = CORDIC_GAIN_INV;
      y_in[0]    = '0;
      z_in[0]    = Z_W'(phase[PHASE_W-3:0]);
      quad_in[0] = phase[PHASE_W-1 -: 2];
      valid_in[0] = in_valid;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!z_ff[i][Z_W-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - Z_W'(STEP_ANGLE[i]);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + Z_W'(STEP_ANGLE[i]);
         end
         quad_in[i+1]  = quad_ff[i];
         valid_in[i+1] = valid_ff[i];
      end
   end

   // fold the first-quadrant result out to the full circle
   assign xl = x_ff[CORDIC_STEPS];
   assign yl = y_ff[CORDIC_STEPS];

   always_comb begin
      unique case (quad_ff[CORDIC_STEPS])
         QUAD_I: begin
            trig_in.cos_v = TRIG_W'(xl);
            trig_in.sin_v = TRIG_W'(yl);
         end
         QUAD_II: begin
            trig_in.cos_v = TRIG_W'(-yl);
            trig_in.sin_v = TRIG_W'(xl);
         end
         QUAD_III: begin
            trig_in.cos_v = TRIG_W'(-xl);
            trig_in.sin_v = TRIG_W'(-yl);
         end
         QUAD_IV: begin
            trig_in.cos_v = TRIG_W'(yl);
            trig_in.sin_v = TRIG_W'(-xl);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         trig_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         trig_valid_ff <= valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      trig_ff <= trig_in;
   end

   assign out_valid = trig_valid_ff;
   assign trig      = trig_ff;

   `ASSERT_IMPLIES(a_residual_small, clock, reset, valid_ff[CORDIC_STEPS],
      (z_ff[CORDIC_STEPS] <= Z_LIM) && (z_ff[CORDIC_STEPS] >= -Z_LIM),
      "cordic residual angle did not converge")
   `ASSERT_IMPLIES(a_sin_bound, clock, reset, trig_valid_ff,
      (trig_ff.sin_v <= TRIG_LIM) && (trig_ff.sin_v >= -TRIG_LIM),
      "sine magnitude above one")
   `ASSERT_IMPLIES(a_cos_bound, clock, reset, trig_valid_ff,
      (trig_ff.cos_v <= TRIG_LIM) && (trig_ff.cos_v >= -TRIG_LIM),
      "cosine magnitude above one")

endmodule

### hdl/rotm_matrix.sv
// Five-stage multiply, sum and round pipeline forming the nine matrix entries.
// Depends on rotm_pkg and the assertion macro header.
`include "euler_to_rotation_matrix_core_macros.svh"
module rotm_matrix
   import rotm_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  trig_type   yaw,
   input  trig_type   pitch,
   input  trig_type   roll,
   output logic       out_valid,
   output matrix_type rot
);

   localparam int SH    = 60 - FRACTION_BITS;
   localparam int RND_W = SUM_W + 1;
   localparam logic signed [RND_W-1:0] RND_HALF =
      {{(RND_W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
   localparam logic signed [RND_W-1:0] LIM =
      {{(RND_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
   localparam logic signed [TRIG_W-1:0] Q30_LIM = TRIG_W'((64'd1 << 30) + 64'd1024);

   // two-factor products carried to the sum stage
   localparam int P_CYCP = 0;
   localparam int P_SYCP = 1;
   localparam int P_CPSR = 2;
   localparam int P_CPCR = 3;
   localparam int P_SYCR = 4;
   localparam int P_CYCR = 5;
   localparam int P_SYSR = 6;
   localparam int P_CYSR = 7;
   localparam int NPROD  = 8;
   localparam int NOUT   = 9;

   logic [MATRIX_LAT-1:0]    v_ff;
   logic signed [PROD_W-1:0] p1_ff [NPROD];
   logic signed [PROD_W-1:0] p1_in [NPROD];
   logic signed [PROD_W-1:0] cysp1_ff, sysp1_ff;
   logic signed [TRIG_W-1:0] sp1_ff, sr1_ff, cr1_ff;
   logic signed [PROD_W-1:0] p2_ff [NPROD];
   logic signed [TRIG_W-1:0] cysp2_ff, sysp2_ff, sp2_ff, sr2_ff, cr2_ff;
   logic signed [PROD_W-1:0] p3_ff [NPROD];
   logic signed [PROD_W-1:0] cyspsr3_ff, cyspcr3_ff, syspsr3_ff, syspcr3_ff;
   logic signed [TRIG_W-1:0] sp3_ff;
   logic signed [SUM_W-1:0]  sum_ff [NOUT];
   logic signed [SUM_W-1:0]  sum_in [NOUT];
   logic signed [RND_W-1:0]  rnd [NOUT];
   logic signed [OUT_W-1:0]  clip [NOUT];
   matrix_type               rot_ff, rot_in;

   always_comb begin
      p1_in[P_CYCP] = mul_q30(yaw.cos_v, pitch.cos_v);
      p1_in[P_SYCP] = mul_q30(yaw.sin_v, pitch.cos_v);
      p1_in[P_CPSR] = mul_q30(pitch.cos_v, roll.sin_v);
      p1_in[P_CPCR] = mul_q30(pitch.cos_v, roll.cos_v);
      p1_in[P_SYCR] = mul_q30(yaw.sin_v, roll.cos_v);
      p1_in[P_CYCR] = mul_q30(yaw.cos_v, roll.cos_v);
      p1_in[P_SYSR] = mul_q30(yaw.sin_v, roll.sin_v);
      p1_in[P_CYSR] = mul_q30(yaw.cos_v, roll.sin_v);
   end

   always_comb begin
      sum_in[0] = SUM_W'(p3_ff[P_CYCP]);
      sum_in[1] = SUM_W'(p3_ff[P_SYCP]);
      sum_in[2] = -(SUM_W'(sp3_ff) <<< 30);
      sum_in[3] = SUM_W'(cyspsr3_ff) - SUM_W'(p3_ff[P_SYCR]);
      sum_in[4] = SUM_W'(syspsr3_ff) + SUM_W'(p3_ff[P_CYCR]);
      sum_in[5] = SUM_W'(p3_ff[P_CPSR]);
      sum_in[6] = SUM_W'(cyspcr3_ff) + SUM_W'(p3_ff[P_SYSR]);
      sum_in[7] = SUM_W'(syspcr3_ff) - SUM_W'(p3_ff[P_CYSR]);
      sum_in[8] = SUM_W'(p3_ff[P_CPCR]);
   end

   // round half up to Q1.F, then clamp to +-1.0
   always_comb begin
      for (int k = 0; k < NOUT; k++) begin
         rnd[k] = (RND_W'(sum_ff[k]) + RND_HALF) >>> SH;
         if (rnd[k] > LIM) begin
            clip[k] = OUT_W'(LIM);
         end else if (rnd[k] < -LIM) begin
            clip[k] = OUT_W'(-LIM);
         end else begin
            clip[k] = OUT_W'(rnd[k]);
         end
      end
      rot_in.fwd_x  = clip[0];
      rot_in.fwd_y  = clip[1];
      rot_in.fwd_z  = clip[2];
      rot_in.left_x = clip[3];
      rot_in.left_y = clip[4];
      rot_in.left_z = clip[5];
      rot_in.up_x   = clip[6];
      rot_in.up_y   = clip[7];
      rot_in.up_z   = clip[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[MATRIX_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p1_in;
      cysp1_ff <= mul_q30(yaw.cos_v, pitch.sin_v);
      sysp1_ff <= mul_q30(yaw.sin_v, pitch.sin_v);
      sp1_ff   <= pitch.sin_v;
      sr1_ff   <= roll.sin_v;
      cr1_ff   <= roll.cos_v;

      p2_ff    <= p1_ff;
      cysp2_ff <= rnd_q30(cysp1_ff);
      sysp2_ff <= rnd_q30(sysp1_ff);
      sp2_ff   <= sp1_ff;
      sr2_ff   <= sr1_ff;
      cr2_ff   <= cr1_ff;

      p3_ff      <= p2_ff;
      cyspsr3_ff <= mul_q30(cysp2_ff, sr2_ff);
      cyspcr3_ff <= mul_q30(cysp2_ff, cr2_ff);
      syspsr3_ff <= mul_q30(sysp2_ff, sr2_ff);
      syspcr3_ff <= mul_q30(sysp2_ff, cr2_ff);
      sp3_ff     <= sp2_ff;

      sum_ff <= sum_in;
      rot_ff <= rot_in;
   end

   assign out_valid = v_ff[MATRIX_LAT-1];
   assign rot       = rot_ff;

   `ASSERT_IMPLIES(a_cysp_bound, clock, reset, v_ff[1],
      (cysp2_ff <= Q30_LIM) && (cysp2_ff >= -Q30_LIM),
      "cos yaw times sin pitch out of range")
   `ASSERT_IMPLIES(a_sysp_bound, clock, reset, v_ff[1],
      (sysp2_ff <= Q30_LIM) && (sysp2_ff >= -Q30_LIM),
      "sin yaw times sin pitch out of range")

endmodule

### hdl/euler_to_rotation_matrix_core.sv
// Yaw-pitch-roll to Z-Y-X rotation matrix, top level.
// Depends on rotm_pkg, rotm_cordic, rotm_matrix and the assertion macro header.
//
// Usage:
//   Request: drive req_yaw_angle, req_pitch_angle and req_roll_angle (binary
//   angles, 2^ANGLE_BITS units per turn) and raise start; the transfer takes
//   place at a rising edge with start high and busy low. busy is high only
//   while reset is asserted, so a new request can enter every cycle.
//   Response: rsp_valid is high for one cycle with the nine Q1.F entries of
//   the forward, left and up columns. There is no back-pressure; the receiver
//   must take each response in the cycle it is shown.
//   Pipeline: 37 register stages. Throughput is one item per cycle.
//   Latency is set by the three parallel 30-step CORDIC pipelines (32 stages
//   with the input and quadrant stages) and the five-stage multiply, sum and
//   round path behind them.
//   Reset: synchronous; it clears all valid bits, so every item in flight is
//   dropped and no response follows.
`include "euler_to_rotation_matrix_core_macros.svh"
module euler_to_rotation_matrix_core
   import rotm_pkg::*;
#(
   parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ANGLE_BITS-1:0]   req_yaw_angle,
   input  logic [ANGLE_BITS-1:0]   req_pitch_angle,
   input  logic [ANGLE_BITS-1:0]   req_roll_angle,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_fwd_x,
   output logic signed [OUT_W-1:0] rsp_fwd_y,
   output logic signed [OUT_W-1:0] rsp_fwd_z,
   output logic signed [OUT_W-1:0] rsp_left_x,
   output logic signed [OUT_W-1:0] rsp_left_y,
   output logic signed [OUT_W-1:0] rsp_left_z,
   output logic signed [OUT_W-1:0] rsp_up_x,
   output logic signed [OUT_W-1:0] rsp_up_y,
   output logic signed [OUT_W-1:0] rsp_up_z
);

   logic       accept;
   logic       yaw_valid, pitch_valid, roll_valid;
   trig_type   yaw_trig, pitch_trig, roll_trig;
   matrix_type rot;

   assign busy   = reset;
   assign accept = start && !busy;

   rotm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_yaw_angle),
      .out_valid (yaw_valid),
      .trig      (yaw_trig)
   );

   rotm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_pitch_angle),
      .out_valid (pitch_valid),
      .trig      (pitch_trig)
   );

   rotm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_roll_angle),
      .out_valid (roll_valid),
      .trig      (roll_trig)
   );

   rotm_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yaw_valid),
      .yaw       (yaw_trig),
      .pitch     (pitch_trig),
      .roll      (roll_trig),
      .out_valid (rsp_valid),
      .rot       (rot)
   );

   assign rsp_fwd_x  = rot.fwd_x;
   assign rsp_fwd_y  = rot.fwd_y;
   assign rsp_fwd_z  = rot.fwd_z;
   assign rsp_left_x = rot.left_x;
   assign rsp_left_y = rot.left_y;
   assign rsp_left_z = rot.left_z;
   assign rsp_up_x   = rot.up_x;
   assign rsp_up_y   = rot.up_y;
   assign rsp_up_z   = rot.up_z;

   // the three trig lanes must stay in lock step
   `ASSERT_ALWAYS(a_lanes_aligned, clock, reset,
      (yaw_valid == pitch_valid) && (pitch_valid == roll_valid),
      "trig lanes out of step")

endmodule

### bench/rotm_checker.sv
`timescale 1ns / 1ps
// Response checker for the rotation matrix core: bit-exact predictor plus scoreboard.
// Depends on rotm_pkg for the output widths and the matrix_type struct.
module rotm_checker
   import rotm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic [15:0] yaw_angle,
   input  logic [15:0] pitch_angle,
   input  logic [15:0] roll_angle,
   input  logic       rsp_valid,
   input  matrix_type rsp_matrix,
   output int         fail_count,
   output int         pending,
   output int         results_seen
);

   localparam int     FRAC       = FRACTION_BITS_DEF;
   localparam longint ENTRY_MAX  = longint'(1) << FRAC;
   localparam longint ENTRY_HALF = longint'(1) << (59 - FRAC);
   localparam longint Q30_HALF   = longint'(1) << 29;
   localparam longint GAIN_Q30   = 64'sh26DD3B6A;

   localparam longint ATAN_Q30 [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   matrix_type expected_q[$];

   // rotation-mode CORDIC over the first quadrant, then quadrant fold-out
   function automatic void trig_of(input logic [15:0] ang, output longint s, output longint c);
      logic [31:0] phase;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0000};
      x = GAIN_Q30;
      y = 0;
      z = {34'd0, phase[29:0]};
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
         end
      end
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Q60 -> Q1.FRAC, round half up, clamp to +-1.0
   function automatic logic signed [OUT_W-1:0] q60_to_entry(input longint v);
      longint r;
      r = (v + ENTRY_HALF) >>> (60 - FRAC);
      if (r > ENTRY_MAX) r = ENTRY_MAX;
      if (r < -ENTRY_MAX) r = -ENTRY_MAX;
      return r[OUT_W-1:0];
   endfunction

   function automatic matrix_type rotation_of(input logic [15:0] yaw_a, pitch_a, roll_a);
      longint sy, cy, sp, cp, sr, cr, cysp, sysp;
      matrix_type m;
      trig_of(yaw_a, sy, cy);
      trig_of(pitch_a, sp, cp);
      trig_of(roll_a, sr, cr);
      cysp = (cy * sp + Q30_HALF) >>> 30;
      sysp = (sy * sp + Q30_HALF) >>> 30;
      m.fwd_x  = q60_to_entry(cy * cp);
      m.fwd_y  = q60_to_entry(sy * cp);
      m.fwd_z  = q60_to_entry(-(sp <<< 30));
      m.left_x = q60_to_entry(cysp * sr - sy * cr);
      m.left_y = q60_to_entry(sysp * sr + cy * cr);
      m.left_z = q60_to_entry(cp * sr);
      m.up_x   = q60_to_entry(cysp * cr + sy * sr);
      m.up_y   = q60_to_entry(sysp * cr - cy * sr);
      m.up_z   = q60_to_entry(cp * cr);
      return m;
   endfunction

   task automatic check_entry(input string name, input logic signed [OUT_W-1:0] exp_v,
                              input logic signed [OUT_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      matrix_type exp_m;
      if (reset) begin
         expected_q.delete();
         fail_count   = 0;
         results_seen = 0;
      end else begin
         if (start && !busy)
            expected_q.push_back(rotation_of(yaw_angle, pitch_angle, roll_angle));
         if (rsp_valid) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $display("%0t: response strobe with no transfer outstanding", $time);
               fail_count++;
            end else begin
               exp_m = expected_q.pop_front();
               check_entry("fwd_x",  exp_m.fwd_x,  rsp_matrix.fwd_x);
               check_entry("fwd_y",  exp_m.fwd_y,  rsp_matrix.fwd_y);
               check_entry("fwd_z",  exp_m.fwd_z,  rsp_matrix.fwd_z);
               check_entry("left_x", exp_m.left_x, rsp_matrix.left_x);
               check_entry("left_y", exp_m.left_y, rsp_matrix.left_y);
               check_entry("left_z", exp_m.left_z, rsp_matrix.left_z);
               check_entry("up_x",   exp_m.up_x,   rsp_matrix.up_x);
               check_entry("up_y",   exp_m.up_y,   rsp_matrix.up_y);
               check_entry("up_z",   exp_m.up_z,   rsp_matrix.up_z);
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

### bench/tb_euler_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Top of the rotation matrix core bench: clock, reset, request stimulus and verdict.
// Depends on rotm_pkg, the core RTL and rotm_checker.
module tb_euler_to_rotation_matrix_core;
   import rotm_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam int N_DIRECTED   = 23;

   typedef enum int {ANG_ANY, ANG_QUADRANT, ANG_EDGE} angle_mode_type;

   // {yaw, pitch, roll}: zero, all ones, quadrant edges, gimbal lock, 45 deg
   localparam logic [47:0] DIRECTED [N_DIRECTED] = '{
      48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h4000_0000_0000, 48'h8000_0000_0000,
      48'hC000_0000_0000, 48'h0000_4000_0000, 48'h0000_C000_0000, 48'h0000_0000_4000,
      48'h0000_0000_8000, 48'h0000_0000_C000, 48'h3FFF_7FFF_BFFF, 48'h4001_8001_C001,
      48'h2000_2000_2000, 48'h6000_A000_E000, 48'h1234_4000_5678, 48'hABCD_C000_8765,
      48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h0001_FFFF_0001, 48'h8000_8000_8000,
      48'hFFFF_0000_8000, 48'h0000_3FFF_0000, 48'h0000_4001_0000
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_yaw_angle   = '0;
   logic [15:0] req_pitch_angle = '0;
   logic [15:0] req_roll_angle  = '0;
   logic        rsp_valid;
   logic signed [OUT_W-1:0] rsp_fwd_x, rsp_fwd_y, rsp_fwd_z;
   logic signed [OUT_W-1:0] rsp_left_x, rsp_left_y, rsp_left_z;
   logic signed [OUT_W-1:0] rsp_up_x, rsp_up_y, rsp_up_z;
   matrix_type  rsp_matrix;

   int  checker_fails;
   int  in_flight;
   int  results_seen;
   int  sent;
   int  idle_cycles;
   bit  no_idle;

   assign rsp_matrix = {rsp_fwd_x, rsp_fwd_y, rsp_fwd_z, rsp_left_x, rsp_left_y,
                        rsp_left_z, rsp_up_x, rsp_up_y, rsp_up_z};

   euler_to_rotation_matrix_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_yaw_angle   (req_yaw_angle),
      .req_pitch_angle (req_pitch_angle),
      .req_roll_angle  (req_roll_angle),
      .rsp_valid       (rsp_valid),
      .rsp_fwd_x       (rsp_fwd_x),
      .rsp_fwd_y       (rsp_fwd_y),
      .rsp_fwd_z       (rsp_fwd_z),
      .rsp_left_x      (rsp_left_x),
      .rsp_left_y      (rsp_left_y),
      .rsp_left_z      (rsp_left_z),
      .rsp_up_x        (rsp_up_x),
      .rsp_up_y        (rsp_up_y),
      .rsp_up_z        (rsp_up_z)
   );

   rotm_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .yaw_angle    (req_yaw_angle),
      .pitch_angle  (req_pitch_angle),
      .roll_angle   (req_roll_angle),
      .rsp_valid    (rsp_valid),
      .rsp_matrix   (rsp_matrix),
      .fail_count   (checker_fails),
      .pending      (in_flight),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("euler_to_rotation_matrix_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [15:0] pick_angle(input angle_mode_type mode);
      logic [15:0] edges [4] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
      case (mode)
         // within a few units of a quadrant boundary, either side
         ANG_QUADRANT: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 8) - 4);
         ANG_EDGE:     return edges[$urandom_range(0, 3)];
         default:      return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic drive_request(input logic [47:0] angles);
      int roll_dice;
      int gap;
      roll_dice = $urandom_range(0, 99);
      if (no_idle || roll_dice < 55) gap = 0;
      else if (roll_dice < 90)       gap = $urandom_range(1, 3);
      else                           gap = $urandom_range(8, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_yaw_angle   <= angles[47:32];
      req_pitch_angle <= angles[31:16];
      req_roll_angle  <= angles[15:0];
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
   endtask

   initial begin
      int             pick;
      angle_mode_type yaw_mode, pitch_mode, roll_mode;
      sent    = 0;
      no_idle = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[k])
         drive_request(DIRECTED[k]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // back-to-back stretches now and then
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         yaw_mode   = ANG_ANY;
         pitch_mode = ANG_ANY;
         roll_mode  = ANG_ANY;
         if (pick >= 6 && pick <= 7) begin
            pitch_mode = ANG_QUADRANT;
         end else if (pick == 8) begin
            yaw_mode   = ANG_QUADRANT;
            pitch_mode = ANG_QUADRANT;
            roll_mode  = ANG_QUADRANT;
         end else if (pick == 9) begin
            yaw_mode   = angle_mode_type'($urandom_range(0, 2));
            pitch_mode = angle_mode_type'($urandom_range(0, 2));
            roll_mode  = angle_mode_type'($urandom_range(0, 2));
         end
         drive_request({pick_angle(yaw_mode), pick_angle(pitch_mode), pick_angle(roll_mode)});
      end
      start <= 1'b0;

      do @(negedge clock); while (in_flight != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d angle triples (%0d directed edge cases, rest random incl. gimbal lock).",
               sent, N_DIRECTED);
      $display("Checked %0d matrices field by field, %0d field errors.",
               results_seen, checker_fails);
      if (checker_fails == 0 && in_flight == 0)
         $display("euler_to_rotation_matrix_core: match");
      else
         $display("euler_to_rotation_matrix_core: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/rotm_pkg.sv
hdl/rotm_cordic.sv
hdl/rotm_matrix.sv
hdl/euler_to_rotation_matrix_core.sv
bench/rotm_checker.sv
bench/tb_euler_to_rotation_matrix_core.sv
